FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent checks clocked on a rising edge, disabled while reset is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AMC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("amc assertion failed");
`define AMC_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("amc forbidden condition");
`else
`define AMC_ASSERT(lbl, clk, rst_n, prop)
`define AMC_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: rtl/amc_pkg.sv
// ---------------------------------------------------------------------------
// amc_pkg
// Shared types and constants of the movement classifier.
// ---------------------------------------------------------------------------
package amc_pkg;

	localparam logic [1:0] ST_IDLE     = 2'd0;
	localparam logic [1:0] ST_NOT_IDLE = 2'd1;
	localparam logic [1:0] ST_WALKING  = 2'd2;

	localparam logic [15:0] GRAVITY_RESET = 16'd1255;
	localparam logic [14:0] SWING_RESET   = 15'd256;
	localparam logic [14:0] REST_RESET    = 15'd13;
	localparam logic [15:0] STILL_RESET   = 16'd128;

	// register indexes on the APB port
	typedef enum logic [1:0] {
		REG_SWING = 2'd0,
		REG_REST  = 2'd1,
		REG_STILL = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [14:0] swing_threshold;
		logic [14:0] rest_threshold;
		logic [15:0] still_span;
	} cfg_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_ROOT,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SCAN,
		B_TAIL,
		B_EVAL,
		B_DIV,
		B_GRAV,
		B_OUT
	} back_state_t;

endpackage

FILE: rtl/accel_movement_classifier_core.sv
// ---------------------------------------------------------------------------
// accel_movement_classifier_core
// Three-axis movement classifier: magnitude, gravity tracking, window state.
// ---------------------------------------------------------------------------
// Flow: the front does its multiply steps, then the root steps and a hand-off;
//   then the back scans the ring, plus a reciprocal multiply and a gravity
//   update when a ring wrap moves the gravity estimate.
// Throughput: per sample the back scans the ring through its single read port
//   and takes no new one until the result is loaded; no scan while filling.
// Reset: arst_n clears control; ring refills before any result comes out.
// ---------------------------------------------------------------------------
module accel_movement_classifier_core import amc_pkg::*; #(
	parameter int WINDOW = 50
) (
	input  logic               clk,
	input  logic               arst_n,
	// sample beat in
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	// result beat out
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         movement_state,
	output logic               state_changed,
	output logic [15:0]        gravity_level,
	// APB configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cfg_t        cfg_q;
	logic        apb_wr;
	reg_idx_t    reg_sel;
	logic        fq_push, fq_full, fq_pop, fq_empty;
	logic [15:0] fq_wdata, fq_rdata;

	// config registers sit at byte offsets 0, 4, 8
	assign pready  = 1'b1;
	assign apb_wr  = psel && penable && pwrite;
	assign reg_sel = reg_idx_t'(paddr[3:2]);

	always_comb begin
		case (reg_sel)
			REG_SWING: prdata = {17'd0, cfg_q.swing_threshold};
			REG_REST:  prdata = {17'd0, cfg_q.rest_threshold};
			REG_STILL: prdata = {16'd0, cfg_q.still_span};
			default:   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.swing_threshold <= SWING_RESET;
			cfg_q.rest_threshold  <= REST_RESET;
			cfg_q.still_span      <= STILL_RESET;
		end else if (apb_wr) begin
			case (reg_sel)
				REG_SWING: cfg_q.swing_threshold <= pwdata[14:0];
				REG_REST:  cfg_q.rest_threshold  <= pwdata[14:0];
				REG_STILL: cfg_q.still_span      <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// front: square sum and root
	amc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.accel_x (accel_x),
		.accel_y (accel_y),
		.accel_z (accel_z),
		.q_full  (fq_full),
		.q_push  (fq_push),
		.q_data  (fq_wdata)
	);

	// decoupling queue of magnitudes
	amc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (fq_push),
		.wdata   (fq_wdata),
		.q_full  (fq_full),
		.rd      (fq_pop),
		.rdata   (fq_rdata),
		.q_empty (fq_empty)
	);

	// back: ring, gravity, classification, result register
	amc_back #(.WINDOW(WINDOW)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_empty        (fq_empty),
		.q_data         (fq_rdata),
		.q_pop          (fq_pop),
		.empty          (empty),
		.pop            (pop),
		.movement_state (movement_state),
		.state_changed  (state_changed),
		.gravity_level  (gravity_level)
	);

endmodule

FILE: rtl/amc_front.sv
// ---------------------------------------------------------------------------
// amc_front
// Takes a sample, forms x*x+y*y+z*z on one multiplier, then the floor root.
// ---------------------------------------------------------------------------
module amc_front import amc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic               q_full,
	output logic               q_push,
	output logic [15:0]        q_data
);

	front_state_t       state_q, state_d;
	logic signed [15:0] ax_q, ay_q, az_q;
	logic [1:0]         step_q;
	logic [31:0]        acc_q;
	logic [31:0]        n_q, root_q, bit_q;
	logic signed [15:0] op;
	logic signed [31:0] prod;
	logic [31:0]        trial;

	always_comb begin
		case (step_q)
			2'd0:    op = ax_q;
			2'd1:    op = ay_q;
			default: op = az_q;
		endcase
	end

	assign prod  = op * op;
	assign trial = root_q + bit_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: if (push) state_d = F_MUL;
			F_MUL:  if (step_q == 2'd2) state_d = F_ROOT;
			F_ROOT: if (bit_q[0]) state_d = F_PUSH;
			F_PUSH: if (!q_full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		full   = (state_q != F_IDLE);
		q_push = (state_q == F_PUSH) && !q_full;
		q_data = root_q[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				ax_q   <= accel_x;
				ay_q   <= accel_y;
				az_q   <= accel_z;
				step_q <= 2'd0;
				acc_q  <= '0;
			end
			F_MUL: begin
				step_q <= step_q + 2'd1;
				acc_q  <= acc_q + $unsigned(prod);
				if (step_q == 2'd2) begin
					n_q    <= acc_q + $unsigned(prod);
					root_q <= '0;
					bit_q  <= 32'h4000_0000;
				end
			end
			F_ROOT: begin
				if (n_q >= trial) begin
					n_q    <= n_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/amc_queue.sv
// ---------------------------------------------------------------------------
// amc_queue
// Two-entry queue of magnitudes between the front and back parts.
// ---------------------------------------------------------------------------
module amc_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr,
	input  logic [15:0] wdata,
	output logic        q_full,
	input  logic        rd,
	output logic [15:0] rdata,
	output logic        q_empty
);

	logic [15:0] slot_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;

	assign q_full  = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);
	assign rdata   = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) slot_q[wp_q] <= wdata;
	end

endmodule

FILE: rtl/amc_back.sv
// ---------------------------------------------------------------------------
// amc_back
// Sample ring, window scan, gravity tracking and classification.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module amc_back import amc_pkg::*; #(
	parameter int WINDOW = 50
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_empty,
	input  logic [15:0] q_data,
	output logic        q_pop,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  movement_state,
	output logic        state_changed,
	output logic [15:0] gravity_level
);

	localparam int AW    = $clog2(WINDOW);
	localparam int SUM_W = 18 + $clog2(WINDOW);
	localparam int CW    = $clog2(WINDOW + 1);
	localparam int PW    = CW + 4;
	localparam int GW    = SUM_W + 2;
	// reciprocal division: |sum| < 2^AB_W, quotient = (|sum| * rcp) >> QS
	localparam int AB_W  = SUM_W - 1;
	localparam int QS    = AB_W + $clog2(10 * WINDOW);
	localparam int RW    = QS - $clog2(WINDOW) + 2;
	localparam int PRW   = AB_W + RW;
	localparam int QW    = PRW - QS;
	localparam logic [RW-1:0] RCP_FILL  =
		RW'(((64'd1 << QS) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
	localparam logic [RW-1:0] RCP_TRACK =
		RW'(((64'd1 << QS) + 64'(10 * WINDOW) - 64'd1) / 64'(10 * WINDOW));

	back_state_t state_q, state_d;

	logic signed [17:0] ring [WINDOW];
	logic [AW-1:0]      slot_q, rd_addr_q;
	logic               filling_q, wrap_q, first_q;
	logic [15:0]        grav_q;
	logic [1:0]         last_q;

	logic               rd_vld_s1, rd_first_s1;
	logic signed [17:0] rd_data_s1;

	logic signed [17:0]      mn_q, mx_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CW-1:0]           hi_q, lo_q, id_q;

	logic [AB_W-1:0] abs_q;
	logic [RW-1:0]   rcp_q;
	logic [PRW-1:0]  prod_q;
	logic            neg_q;

	logic               wrap;
	logic signed [17:0] mag;
	logic signed [17:0] sw, rs;
	logic signed [18:0] spread;
	logic               stationary;
	logic [QW-1:0]      quo;
	logic signed [GW-1:0] gsum;
	logic [PW-1:0]      id4, id10, hi10, lo10;
	logic [1:0]         cur;
	logic               load_out;

	assign wrap       = (slot_q == AW'(WINDOW - 1));
	assign mag        = $signed({2'b00, q_data}) - $signed({2'b00, grav_q});
	assign sw         = $signed({3'b000, cfg.swing_threshold});
	assign rs         = $signed({3'b000, cfg.rest_threshold});
	assign spread     = $signed({mx_q[17], mx_q}) - $signed({mn_q[17], mn_q});
	assign stationary = spread < $signed({3'b000, cfg.still_span});
	assign quo        = prod_q[PRW-1:QS];
	assign gsum       = $signed({{(GW-16){1'b0}}, grav_q}) +
		(neg_q ? -$signed({{(GW-QW){1'b0}}, quo}) : $signed({{(GW-QW){1'b0}}, quo}));

	assign id4  = PW'(id_q) << 2;
	assign id10 = PW'(id_q) * PW'(10);
	assign hi10 = PW'(hi_q) * PW'(10);
	assign lo10 = PW'(lo_q) * PW'(10);

	always_comb begin
		if (id4 > PW'(WINDOW) || stationary)
			cur = ST_IDLE;
		else if (hi10 > PW'(WINDOW) && lo10 > PW'(WINDOW) && id10 < PW'(WINDOW))
			cur = ST_WALKING;
		else
			cur = ST_NOT_IDLE;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: if (!q_empty && (wrap || !filling_q)) state_d = B_SCAN;
			B_SCAN: if (rd_addr_q == AW'(WINDOW - 1)) state_d = B_TAIL;
			B_TAIL: state_d = B_EVAL;
			B_EVAL: state_d = (wrap_q && stationary) ? B_DIV : B_OUT;
			B_DIV:  state_d = B_GRAV;
			B_GRAV: state_d = B_OUT;
			B_OUT:  if (empty || pop) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop    = (state_q == B_IDLE) && !q_empty;
		load_out = (state_q == B_OUT) && (empty || pop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			slot_q    <= '0;
			filling_q <= 1'b1;
			grav_q    <= GRAVITY_RESET;
			last_q    <= ST_NOT_IDLE;
			empty     <= 1'b1;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == B_SCAN);
			if (q_pop) begin
				slot_q <= wrap ? '0 : slot_q + AW'(1);
				if (wrap) filling_q <= 1'b0;
			end
			if (state_q == B_GRAV) begin
				if (gsum < 0)
					grav_q <= '0;
				else if (gsum > $signed(GW'(65535)))
					grav_q <= 16'hFFFF;
				else
					grav_q <= gsum[15:0];
			end
			if (load_out) begin
				empty  <= 1'b0;
				last_q <= cur;
			end else if (pop) begin
				empty <= 1'b1;
			end
		end
	end

	// ring memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (q_pop) ring[slot_q] <= mag;
		rd_data_s1 <= ring[rd_addr_q];
	end

	always_ff @(posedge clk) begin
		rd_first_s1 <= (rd_addr_q == '0);
		if (q_pop) begin
			wrap_q    <= wrap;
			first_q   <= filling_q;
			rd_addr_q <= '0;
		end else if (state_q == B_SCAN && rd_addr_q != AW'(WINDOW - 1)) begin
			rd_addr_q <= rd_addr_q + AW'(1);
		end
		if (rd_vld_s1) begin
			if (rd_first_s1) begin
				mn_q  <= rd_data_s1;
				mx_q  <= rd_data_s1;
				sum_q <= SUM_W'(rd_data_s1);
				hi_q  <= CW'(rd_data_s1 > sw);
				lo_q  <= CW'(!(rd_data_s1 > sw) && rd_data_s1 < -sw);
				id_q  <= CW'(!(rd_data_s1 > sw) && !(rd_data_s1 < -sw) &&
					rd_data_s1 < rs && rd_data_s1 > -rs);
			end else begin
				if (rd_data_s1 < mn_q) mn_q <= rd_data_s1;
				if (rd_data_s1 > mx_q) mx_q <= rd_data_s1;
				sum_q <= sum_q + SUM_W'(rd_data_s1);
				if (rd_data_s1 > sw)
					hi_q <= hi_q + CW'(1);
				else if (rd_data_s1 < -sw)
					lo_q <= lo_q + CW'(1);
				else if (rd_data_s1 < rs && rd_data_s1 > -rs)
					id_q <= id_q + CW'(1);
			end
		end
		// |sum|*rcp gives mean (mean/10 when tracking); sign restored afterwards
		if (state_q == B_EVAL) begin
			neg_q <= sum_q[SUM_W-1];
			abs_q <= sum_q[SUM_W-1] ? AB_W'(-sum_q) : AB_W'(sum_q);
			rcp_q <= first_q ? RCP_FILL : RCP_TRACK;
		end else if (state_q == B_DIV) begin
			prod_q <= PRW'(abs_q) * PRW'(rcp_q);
		end
		if (load_out) begin
			movement_state <= cur;
			state_changed  <= (cur != last_q);
			gravity_level  <= grav_q;
		end
	end

	`AMC_ASSERT(a_div_on_wrap, clk, arst_n, (state_q == B_DIV) |-> wrap_q)
	`AMC_ASSERT(a_scan_reads, clk, arst_n, (state_q == B_SCAN) |=> rd_vld_s1)
	`AMC_NEVER(a_no_result_in_fill, clk, arst_n, filling_q && !empty)

endmodule
